@@ design/tbsm_pkg.sv @@
// Shared types and codes for the triple buffer slot manager.
`default_nettype none

package tbsm_pkg;

	localparam int SLOT_W = 3;
	localparam int OP_W   = 2;

	typedef logic [OP_W-1:0]   opcode_t;
	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef logic [1:0]        slot_state_t;

	localparam opcode_t OP_CLAIM   = 2'd0;
	localparam opcode_t OP_COMMIT  = 2'd1;
	localparam opcode_t OP_ACQUIRE = 2'd2;
	localparam opcode_t OP_RELEASE = 2'd3;

	localparam slot_state_t ST_FREE      = 2'd0;
	localparam slot_state_t ST_WRITING   = 2'd1;
	localparam slot_state_t ST_PUBLISHED = 2'd2;
	localparam slot_state_t ST_READING   = 2'd3;

	typedef struct packed {
		logic      granted;
		slot_idx_t slot_out;
	} result_t;

endpackage

`default_nettype wire

@@ design/tbsm_if.sv @@
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface tbsm_in_if;
	logic                 valid;
	logic                 ready;
	tbsm_pkg::opcode_t    opcode;
	tbsm_pkg::slot_idx_t  slot;

	modport source (output valid, output opcode, output slot, input ready);
	modport sink   (input valid, input opcode, input slot, output ready);
endinterface

interface tbsm_out_if;
	logic                 valid;
	logic                 ready;
	logic                 granted;
	tbsm_pkg::slot_idx_t  slot_out;

	modport source (output valid, output granted, output slot_out, input ready);
	modport sink   (input valid, input granted, input slot_out, output ready);
endinterface

`default_nettype wire

@@ design/triple_buffer_slot_manager.sv @@
// Top level of the triple buffer slot manager: request/response pipeline and slot state.
`default_nettype none

// Ownership tracker for SLOT_COUNT frame buffer slots shared by one producer
// and one consumer. Each request carries an opcode (claim, commit, acquire,
// release) and a slot index; each request produces exactly one response with
// a granted flag and a slot index (zero when not granted). Commit and release
// with a slot index at or beyond SLOT_COUNT change nothing and answer not
// granted. Throughput is one item per clock while the consumer does not
// stall. Each item passes through the request register and then the
// response register. The rate is set by the single read-modify-write of
// the slot state registers, which completes in the cycle an item leaves
// the request register, so the following item always sees the updated
// state. The response register holds a result while the consumer stalls,
// and the request register takes a new item whenever it is empty or
// draining.
module triple_buffer_slot_manager #(
	parameter int SLOT_COUNT = 3
) (
	input  wire       clk,
	input  wire       arst_n,
	tbsm_in_if.sink   req,
	tbsm_out_if.source rsp
);

	// Request stage.
	logic                valid_s1;
	tbsm_pkg::opcode_t   opcode_s1;
	tbsm_pkg::slot_idx_t slot_s1;

	// Slot ownership state.
	logic [SLOT_COUNT-1:0][1:0] slot_state_q;
	logic                       pub_valid_q;
	tbsm_pkg::slot_idx_t        pub_index_q;

	// Response register.
	logic              out_valid_q;
	tbsm_pkg::result_t result_q;

	// Step logic outputs.
	logic [SLOT_COUNT-1:0][1:0] slot_state_nxt;
	logic                       pub_valid_nxt;
	tbsm_pkg::slot_idx_t        pub_index_nxt;
	tbsm_pkg::result_t          result_nxt;

	logic advance;
	logic accept;

	// Advance the request stage when the response register is free or draining.
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	tbsm_step #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_step (
		.opcode        (opcode_s1),
		.slot          (slot_s1),
		.state_cur     (slot_state_q),
		.pub_valid_cur (pub_valid_q),
		.pub_index_cur (pub_index_q),
		.state_nxt     (slot_state_nxt),
		.pub_valid_nxt (pub_valid_nxt),
		.pub_index_nxt (pub_index_nxt),
		.result        (result_nxt)
	);

	// Request stage valid: load on accept, drop when the item moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Request payload: hold until a new item is accepted.
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= req.opcode;
			slot_s1   <= req.slot;
		end
	end

	// Slot state: all free, nothing published after reset; update per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_state_q <= '0;
			pub_valid_q  <= 1'b0;
			pub_index_q  <= '0;
		end else if (advance) begin
			slot_state_q <= slot_state_nxt;
			pub_valid_q  <= pub_valid_nxt;
			pub_index_q  <= pub_index_nxt;
		end
	end

	// Response valid: set on advance, clear once taken with nothing behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.granted  = result_q.granted;
	assign rsp.slot_out = result_q.slot_out;

endmodule

`default_nettype wire

@@ design/tbsm_step.sv @@
// Next-state and response logic for one slot manager operation.
`default_nettype none

module tbsm_step #(
	parameter int SLOT_COUNT = 3
) (
	input  wire tbsm_pkg::opcode_t                    opcode,
	input  wire tbsm_pkg::slot_idx_t                  slot,
	input  wire [SLOT_COUNT-1:0][1:0]                 state_cur,
	input  wire                                       pub_valid_cur,
	input  wire tbsm_pkg::slot_idx_t                  pub_index_cur,
	output logic [SLOT_COUNT-1:0][1:0]                state_nxt,
	output logic                                      pub_valid_nxt,
	output tbsm_pkg::slot_idx_t                       pub_index_nxt,
	output tbsm_pkg::result_t                         result
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [tbsm_pkg::SLOT_W:0] SLOT_LIMIT = (tbsm_pkg::SLOT_W+1)'(SLOT_COUNT);

	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic             pub_ok;
	logic             slot_ok;
	logic [IDX_W-1:0] pub_idx;
	logic [IDX_W-1:0] slot_idx;

	assign pub_idx  = pub_index_cur[IDX_W-1:0];
	assign slot_idx = slot[IDX_W-1:0];
	assign pub_ok   = pub_valid_cur && ({1'b0, pub_index_cur} < SLOT_LIMIT);
	assign slot_ok  = {1'b0, slot} < SLOT_LIMIT;

	// Lowest free slot wins: scan downward so the last hit is the lowest.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (state_cur[i] == tbsm_pkg::ST_FREE) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_nxt     = state_cur;
		pub_valid_nxt = pub_valid_cur;
		pub_index_nxt = pub_index_cur;
		result        = '0;
		case (opcode)
			tbsm_pkg::OP_CLAIM: begin
				if (free_found) begin
					state_nxt[free_idx] = tbsm_pkg::ST_WRITING;
					result.granted      = 1'b1;
					result.slot_out     = tbsm_pkg::SLOT_W'(free_idx);
				end else if (pub_ok) begin
					// Reclaim the unread published frame.
					state_nxt[pub_idx] = tbsm_pkg::ST_WRITING;
					pub_valid_nxt      = 1'b0;
					result.granted     = 1'b1;
					result.slot_out    = pub_index_cur;
				end
			end
			tbsm_pkg::OP_COMMIT: begin
				if (slot_ok) begin
					if (pub_ok) begin
						state_nxt[pub_idx] = tbsm_pkg::ST_FREE;
					end
					state_nxt[slot_idx] = tbsm_pkg::ST_PUBLISHED;
					pub_valid_nxt       = 1'b1;
					pub_index_nxt       = slot;
					result.granted      = 1'b1;
					result.slot_out     = slot;
				end
			end
			tbsm_pkg::OP_ACQUIRE: begin
				if (pub_ok) begin
					state_nxt[pub_idx] = tbsm_pkg::ST_READING;
					pub_valid_nxt      = 1'b0;
					result.granted     = 1'b1;
					result.slot_out    = pub_index_cur;
				end
			end
			tbsm_pkg::OP_RELEASE: begin
				if (slot_ok && state_cur[slot_idx] == tbsm_pkg::ST_READING) begin
					state_nxt[slot_idx] = tbsm_pkg::ST_FREE;
					result.granted      = 1'b1;
					result.slot_out     = slot;
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

endmodule

`default_nettype wire
